// ===== hdl/pirl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pirl_pkg;

  // Default sizing of the list.
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the channels.
  localparam int CMD_W   = 3;
  localparam int POS_W   = 6;
  localparam int ITEM_W  = 32;
  localparam int RES_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_AT  = 3'd0,
    CMD_REMOVE_AT  = 3'd1,
    CMD_REPLACE_AT = 3'd2,
    CMD_READ_AT    = 3'd3,
    CMD_PUSH       = 3'd4,
    CMD_POP        = 3'd5,
    CMD_TOP        = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Broadcast control to every cell of the row.
  typedef struct packed {
    logic shift_up;    // open a gap at the target position
    logic shift_down;  // close the gap at the target position
    logic wr;          // overwrite the target cell
    logic rd;          // target cell drives the read bus
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/pirl_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pirl_in_if;
  import pirl_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [POS_W-1:0]  position;
  logic [ITEM_W-1:0] item_value;

  modport source (output valid, command, position, item_value, input ready);
  modport sink   (input valid, command, position, item_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/pirl_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pirl_out_if;
  import pirl_pkg::*;

  logic               valid;
  logic               ready;
  logic [RES_W-1:0]   result_value;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, result_value, status, entry_count, input ready);
  modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/positional_insert_remove_list_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Positional insert/remove list. The block keeps an ordered list of up to
// DEPTH data words in a row of cells, one word per cell, together with a
// live count. Each input beat carries one command (insert at a position,
// remove at a position, replace, read, push, pop or top) and yields exactly
// one output beat with the value read or removed, a status (ok, position out
// of range, list full, list empty) and the count after the command. Inserts
// and removals shift every later cell by one place in the same clock, so a new
// beat can be accepted in every cycle; the result appears in an output register
// in the cycle after acceptance, and the input is only held back while that
// register holds a beat that the sink has not taken. The read path is a select
// over all cells, so its depth grows with DEPTH. Entries above the count hold
// stale data and are never reported.
module positional_insert_remove_list_unit #(
  parameter int DEPTH      = pirl_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = pirl_pkg::DATA_WIDTH_DEF
) (
  input wire         clk,
  input wire         rst_n,
  pirl_in_if.sink    in_ch,
  pirl_out_if.source out_ch
);
  import pirl_pkg::*;

  // Count width holds DEPTH itself; compare width also covers the position field.
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  out_valid_r;
  logic [RES_W-1:0]      result_value_r;
  logic [STAT_W-1:0]     status_r;
  logic [COUNT_W-1:0]    entry_count_r;

  logic                  in_fire;
  cmd_t                  cmd;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         cnt_w;
  logic                  full;
  logic                  empty;
  logic                  pos_ok;
  cell_ctrl_t            dec_ctrl;
  cell_ctrl_t            ctrl;
  logic [CW-1:0]         tgt_pos;
  status_t               status;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rd_bus;

  logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd [DEPTH];

  // The output register parts the two sides: a new beat may enter whenever
  // the register is empty or is being emptied in this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign cmd   = cmd_t'(in_ch.command);
  assign pos_w = PW'(in_ch.position);
  assign cnt_w = PW'(count_r);
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign pos_ok = (pos_w < cnt_w);
  assign wdata = DATA_WIDTH'(in_ch.item_value);

  // Command decode. Positions reaching the cells are always below the count
  // (or equal to it for an append), so they fit the count width.
  always_comb begin
    dec_ctrl  = '0;
    tgt_pos   = '0;
    status    = ST_OK;
    count_nxt = count_r;
    case (cmd)
      CMD_INSERT_AT, CMD_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          dec_ctrl.shift_up = 1'b1;
          // An insert beyond the count is clamped, which makes it an append.
          if (cmd == CMD_PUSH || pos_w > cnt_w) begin
            tgt_pos = count_r;
          end else begin
            tgt_pos = CW'(pos_w);
          end
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_REMOVE_AT: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          dec_ctrl.shift_down = 1'b1;
          dec_ctrl.rd         = 1'b1;
          tgt_pos             = CW'(pos_w);
          count_nxt           = count_r - CW'(1);
        end
      end
      CMD_REPLACE_AT: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          dec_ctrl.wr = 1'b1;
          tgt_pos     = CW'(pos_w);
        end
      end
      CMD_READ_AT: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          dec_ctrl.rd = 1'b1;
          tgt_pos     = CW'(pos_w);
        end
      end
      CMD_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          dec_ctrl.shift_down = 1'b1;
          dec_ctrl.rd         = 1'b1;
          tgt_pos             = count_r - CW'(1);
          count_nxt           = count_r - CW'(1);
        end
      end
      CMD_TOP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          dec_ctrl.rd = 1'b1;
          tgt_pos     = count_r - CW'(1);
        end
      end
      default: begin
        // The unused command code leaves the list alone and reports ok.
      end
    endcase
  end

  // Cells only move when a beat is really taken.
  always_comb begin
    ctrl = in_fire ? dec_ctrl : '0;
  end

  // The row of cells. Each cell sees its two neighbours; the ends see zero,
  // which only ever lands in cells above the count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_q;
    logic [DATA_WIDTH-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_inner_l
      assign left_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_inner_r
      assign right_q = cell_q[i+1];
    end

    pirl_cell #(
      .IDX        (i),
      .CW         (CW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .tgt_pos (tgt_pos),
      .wdata   (wdata),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i]),
      .rd_data (cell_rd[i])
    );
  end

  // Only the addressed cell drives a non-zero word, so an OR gathers it. A
  // failed command selects no cell and therefore reads as zero.
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_value_r <= RES_W'(rd_bus);
      status_r       <= status;
      entry_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = result_value_r;
  assign out_ch.status       = status_r;
  assign out_ch.entry_count  = entry_count_r;

endmodule

`default_nettype wire

// ===== hdl/pirl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pirl_cell #(
  parameter int IDX        = 0,
  parameter int CW         = 7,
  parameter int DATA_WIDTH = 32
) (
  input  wire                        clk,
  input  wire  pirl_pkg::cell_ctrl_t ctrl,
  input  wire  [CW-1:0]              tgt_pos,
  input  wire  [DATA_WIDTH-1:0]      wdata,
  input  wire  [DATA_WIDTH-1:0]      left_q,
  input  wire  [DATA_WIDTH-1:0]      right_q,
  output logic [DATA_WIDTH-1:0]      q,
  output logic [DATA_WIDTH-1:0]      rd_data
);
  import pirl_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [DATA_WIDTH-1:0] entry_r;
  logic [DATA_WIDTH-1:0] entry_nxt;
  logic                  at_tgt;
  logic                  above_tgt;

  assign at_tgt    = (MY_IDX == tgt_pos);
  assign above_tgt = (MY_IDX > tgt_pos);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.shift_up) begin
      if (above_tgt) begin
        entry_nxt = left_q;
      end else if (at_tgt) begin
        entry_nxt = wdata;
      end
    end else if (ctrl.shift_down) begin
      if (above_tgt || at_tgt) begin
        entry_nxt = right_q;
      end
    end else if (ctrl.wr && at_tgt) begin
      entry_nxt = wdata;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q       = entry_r;
  assign rd_data = (ctrl.rd && at_tgt) ? entry_r : '0;

endmodule

`default_nettype wire

// ===== tb/list_result_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the list unit, keeps its own copy of the list and
// compares every result beat with the oldest outstanding prediction.
module list_result_checker (
  input  logic clk,
  input  logic rst_n,
  pirl_in_if   in_mon,
  pirl_out_if  out_mon,
  output int   fail_count,
  output int   pending
);
  import pirl_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [RES_W-1:0]   value;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic [DATA_WIDTH_DEF-1:0] list_words [LIST_DEPTH];
  int                        list_len;
  list_result_t              expected_results [$];

  // Removes the word at index at and closes the gap behind it.
  function automatic logic [RES_W-1:0] take_word(int at);
    logic [RES_W-1:0] word;
    int               i;
    word = list_words[at];
    for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
    list_len--;
    return word;
  endfunction

  // Applies one command to the local list and returns the result it gives.
  function automatic list_result_t apply_command(logic [CMD_W-1:0] code,
                                                 logic [POS_W-1:0] pos,
                                                 logic [ITEM_W-1:0] word);
    list_result_t r;
    int           at;
    int           i;
    r.value  = '0;
    r.status = ST_OK;
    case (code)
      CMD_INSERT_AT, CMD_PUSH: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          at = (code == CMD_PUSH || int'(pos) > list_len) ? list_len : int'(pos);
          for (i = list_len; i > at; i--) list_words[i] = list_words[i - 1];
          list_words[at] = word;
          list_len++;
        end
      end
      CMD_REMOVE_AT: begin
        if (int'(pos) >= list_len) r.status = ST_RANGE;
        else r.value = take_word(int'(pos));
      end
      CMD_REPLACE_AT: begin
        if (int'(pos) >= list_len) r.status = ST_RANGE;
        else list_words[pos] = word;
      end
      CMD_READ_AT: begin
        if (int'(pos) >= list_len) r.status = ST_RANGE;
        else r.value = list_words[pos];
      end
      CMD_POP: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.value = take_word(list_len - 1);
      end
      CMD_TOP: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.value = list_words[list_len - 1];
      end
      default: begin
        // The spare command code leaves the list alone.
      end
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
    list_len   = 0;
  end

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst_n) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(apply_command(in_mon.command, in_mon.position,
                                                 in_mon.item_value));
      if (out_mon.valid && out_mon.ready) begin
        got.value  = out_mon.result_value;
        got.status = status_t'(out_mon.status);
        got.count  = out_mon.entry_count;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result beat with nothing outstanding: %s",
                     $time, $sformatf("value %h status %0d count %0d",
                                      got.value, got.status, got.count));
        end else begin
          want = expected_results.pop_front();
          if (got.value !== want.value || got.status !== want.status ||
              got.count !== want.count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected %s, got %s", $time,
                       $sformatf("value %h status %0d count %0d",
                                 want.value, want.status, want.count),
                       $sformatf("value %h status %0d count %0d",
                                 got.value, got.status, got.count));
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the positional list unit. The checker beside the
// block does all the prediction; this module only decides what to send, when
// to send it and when the sink is willing to take results.
module tb_top;
  import pirl_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1250;
  // The final stretch of the random part runs with both sides at full rate.
  localparam int QUIET_TAIL   = 150;
  // The sink holds off for this many cycles once, while commands keep coming.
  localparam int LONG_HOLD    = 48;

  // The one command code that the package leaves unnamed; the block must
  // treat it as a no-operation.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    MODE_GROW,
    MODE_SHRINK,
    MODE_MIX
  } traffic_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  pirl_in_if  in_ch ();
  pirl_out_if out_ch ();

  int fail_count;
  int pending;

  // Knobs set by the stimulus; the first two are read by the sink process.
  bit rx_stalls_on = 1'b1;
  int hold_cycles_req = 0;
  bit tx_gaps_on = 1'b1;

  // A shadow of the list length, kept only so that positions can be aimed at
  // live entries; the checker owns the real prediction.
  int fill_level = 0;
  int full_hits = 0;
  int empty_hits = 0;
  int beats_sent = 0;

  positional_insert_remove_list_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_result_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // A 2 ns clock: high for one nanosecond, low for the next.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the handshake ever locks up.
  initial begin
    #500000;
    $display("== FAIL ==");
    $finish;
  end

  // The sink. Ready changes only on falling edges. It normally takes every
  // beat, now and then drops ready for a short burst, and once holds off for
  // a long stretch that it counts itself, so that the output register stays
  // full and the block has to push back on its input.
  initial begin
    int hold_len;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles_req != 0) begin
        hold_len        = hold_cycles_req;
        hold_cycles_req = 0;
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else if (rst_n && rx_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one command beat and holds it until the block takes it. The task
  // starts and ends on a falling edge. Valid is left high on return, so that
  // back-to-back beats keep it high without a glitch.
  task automatic issue_command(logic [CMD_W-1:0] code, logic [POS_W-1:0] pos,
                               logic [ITEM_W-1:0] word);
    in_ch.valid      <= 1'b1;
    in_ch.command    <= code;
    in_ch.position   <= pos;
    in_ch.item_value <= word;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    beats_sent++;
    // Follow the length of the list so that later positions hit live words.
    case (code)
      CMD_INSERT_AT, CMD_PUSH: begin
        if (fill_level < LIST_DEPTH) begin
          fill_level++;
          if (fill_level == LIST_DEPTH) full_hits++;
        end
      end
      CMD_REMOVE_AT, CMD_POP: begin
        if (fill_level > 0 && (code == CMD_POP || int'(pos) < fill_level)) begin
          fill_level--;
          if (fill_level == 0) empty_hits++;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Drops valid for a few cycles; the payload wanders meanwhile, which the
  // block must ignore.
  task automatic idle_gap(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) begin
      in_ch.command    <= CMD_W'($urandom);
      in_ch.position   <= POS_W'($urandom);
      in_ch.item_value <= $urandom;
      @(negedge clk);
    end
  endtask

  // Stops offering beats until every result has been taken by the sink.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Chooses a command. Each mode leans towards growing the list, shrinking
  // it or touching it in place, so that the random part walks the count from
  // empty to full and back again.
  function automatic logic [CMD_W-1:0] pick_command(traffic_mode_t mode);
    int grow_pct;
    int shrink_pct;
    int roll;
    case (mode)
      MODE_GROW:   begin grow_pct = 65; shrink_pct = 15; end
      MODE_SHRINK: begin grow_pct = 15; shrink_pct = 65; end
      default:     begin grow_pct = 30; shrink_pct = 30; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < grow_pct)
      return $urandom_range(0, 1) ? CMD_INSERT_AT : CMD_PUSH;
    if (roll < grow_pct + shrink_pct)
      return $urandom_range(0, 1) ? CMD_REMOVE_AT : CMD_POP;
    case ($urandom_range(0, 9))
      0, 1, 2: return CMD_REPLACE_AT;
      3, 4, 5: return CMD_READ_AT;
      6, 7, 8: return CMD_TOP;
      default: return CMD_UNUSED;
    endcase
  endfunction

  // Mostly a live index, sometimes the edges of the field or the count itself,
  // which is just past the end for the positional reads and writes.
  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return (fill_level > 63) ? POS_W'(63) : POS_W'(fill_level);
      3:       return POS_W'($urandom);
      default: begin
        if (fill_level > 0) return POS_W'($urandom_range(0, fill_level - 1));
        return POS_W'($urandom);
      end
    endcase
  endfunction

  function automatic logic [ITEM_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    traffic_mode_t mode;
    int            seg_left;
    int            n;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_INSERT_AT;
    in_ch.position   = '0;
    in_ch.item_value = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: every command but push on an empty list, clamping of an
    // insert position, inserts at the front and in the middle, reads at the
    // first and last entry and just past the end, and draining to empty.
    issue_command(CMD_POP, '0, '0);
    issue_command(CMD_TOP, '0, '0);
    issue_command(CMD_REMOVE_AT, '0, '0);
    issue_command(CMD_READ_AT, '1, '0);
    issue_command(CMD_REPLACE_AT, '0, 32'h1234_5678);
    issue_command(CMD_UNUSED, '1, '1);
    issue_command(CMD_INSERT_AT, '1, '1);
    issue_command(CMD_INSERT_AT, '0, '0);
    issue_command(CMD_PUSH, '0, 32'hA5A5_A5A5);
    issue_command(CMD_INSERT_AT, POS_W'(1), 32'h5A5A_5A5A);
    issue_command(CMD_READ_AT, '0, '0);
    issue_command(CMD_READ_AT, POS_W'(3), '0);
    issue_command(CMD_READ_AT, POS_W'(4), '0);
    issue_command(CMD_REPLACE_AT, POS_W'(3), 32'h8000_0001);
    issue_command(CMD_TOP, '0, '0);
    issue_command(CMD_UNUSED, POS_W'(2), 32'hDEAD_BEEF);
    issue_command(CMD_REMOVE_AT, POS_W'(1), '0);
    issue_command(CMD_REMOVE_AT, POS_W'(3), '0);
    issue_command(CMD_POP, '0, '0);
    issue_command(CMD_POP, '0, '0);
    issue_command(CMD_POP, '0, '0);
    issue_command(CMD_POP, '0, '0);
    issue_command(CMD_REMOVE_AT, '1, '0);
    wait_for_drain();

    // Random part. The first two stretches lean towards growing the list and then
    // towards shrinking it; after that the mode is chosen at random.
    mode     = MODE_GROW;
    seg_left = 110;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        if (mode == MODE_GROW && n < 200) mode = MODE_SHRINK;
        else mode = traffic_mode_t'($urandom_range(0, 2));
        seg_left = (n < 200) ? 110 : $urandom_range(40, 120);
        // Now and then the sender waits for the pipeline to run dry.
        if ($urandom_range(0, 3) == 0) wait_for_drain();
      end
      if (n == 600) wait_for_drain();
      if (n == 300) hold_cycles_req = LONG_HOLD;
      if (n == RANDOM_ITEMS - QUIET_TAIL) begin
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
      end
      if (tx_gaps_on && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 4));
      issue_command(pick_command(mode), pick_position(), pick_word());
      seg_left--;
    end

    // All commands are in; let the last results come out, then allow a few
    // more cycles for any stray beat to show itself.
    wait_for_drain();
    repeat (10) @(negedge clk);

    $display("Sent %0d command beats, %0d of them directed, with stalls on both sides.",
             beats_sent, beats_sent - RANDOM_ITEMS);
    $display("The list reached its full depth of %0d entries %0d times and ran empty %0d times.",
             LIST_DEPTH, full_hits, empty_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pirl_pkg.sv
hdl/pirl_in_if.sv
hdl/pirl_out_if.sv
hdl/pirl_cell.sv
hdl/positional_insert_remove_list_unit.sv
tb/list_result_checker.sv
tb/tb_top.sv
